// File: rtl/crrd_pkg.sv
// Shared types, register indexes and the modifier-to-table decoder.
package crrd_pkg;

  localparam int ChordW = 8;
  localparam int ModW   = 5;
  localparam int TimeW  = 32;
  localparam int TabW   = 3;
  localparam int CfgW   = 16;
  localparam int IdxW   = 8;

  localparam logic [IdxW-1:0] REG_DOUBLE_CLICK = 8'd0;
  localparam logic [IdxW-1:0] REG_HOLD_DELAY   = 8'd1;

  localparam logic [CfgW-1:0] DOUBLE_CLICK_RESET = 16'd300;
  localparam logic [CfgW-1:0] HOLD_DELAY_RESET   = 16'd500;

  localparam logic [ModW-1:0] MOD_NONE       = 5'h00;
  localparam logic [ModW-1:0] MOD_SHIFT      = 5'h01;
  localparam logic [ModW-1:0] MOD_NUMERIC    = 5'h02;
  localparam logic [ModW-1:0] MOD_FUNCTION   = 5'h04;
  localparam logic [ModW-1:0] MOD_CONTROL    = 5'h08;
  localparam logic [ModW-1:0] MOD_ALT        = 5'h10;
  localparam logic [ModW-1:0] MOD_CTRL_SHIFT = 5'h09;

  localparam logic [TabW-1:0] TAB_NONE       = 3'd0;
  localparam logic [TabW-1:0] TAB_SHIFT      = 3'd1;
  localparam logic [TabW-1:0] TAB_NUMERIC    = 3'd2;
  localparam logic [TabW-1:0] TAB_FUNCTION   = 3'd3;
  localparam logic [TabW-1:0] TAB_CONTROL    = 3'd4;
  localparam logic [TabW-1:0] TAB_ALT        = 3'd5;
  localparam logic [TabW-1:0] TAB_CTRL_SHIFT = 3'd6;

  typedef struct packed {
    logic              listed;
    logic [TabW-1:0]   table_num;
  } tab_sel_t;

  typedef struct packed {
    logic                emit;
    logic [TabW-1:0]     emit_table;
    logic [ChordW-1:0]   emit_chord;
    logic                repeating;
  } result_t;

  function automatic tab_sel_t table_of(input logic [ModW-1:0] mods);
    tab_sel_t s;
    s.listed = 1'b1;
    unique case (mods)
      MOD_NONE:       s.table_num = TAB_NONE;
      MOD_SHIFT:      s.table_num = TAB_SHIFT;
      MOD_NUMERIC:    s.table_num = TAB_NUMERIC;
      MOD_FUNCTION:   s.table_num = TAB_FUNCTION;
      MOD_CONTROL:    s.table_num = TAB_CONTROL;
      MOD_ALT:        s.table_num = TAB_ALT;
      MOD_CTRL_SHIFT: s.table_num = TAB_CTRL_SHIFT;
      default: begin
        s.listed    = 1'b0;
        s.table_num = TAB_NONE;
      end
    endcase
    return s;
  endfunction

endpackage

// File: rtl/crrd_engine.sv
// Chord release, double-press and auto-repeat state with its next-result logic.
module crrd_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [crrd_pkg::ChordW-1:0] chord,
  input  logic [crrd_pkg::ModW-1:0]   modifier_bits,
  input  logic [crrd_pkg::TimeW-1:0]  time_ms,
  input  logic [crrd_pkg::CfgW-1:0]   double_click_window,
  input  logic [crrd_pkg::CfgW-1:0]   hold_delay,
  output crrd_pkg::result_t           result
);
  import crrd_pkg::*;

  logic [ChordW-1:0] previous_chord, previous_chord_next;
  logic              sent_mark, sent_mark_next;
  logic [ChordW-1:0] last_sent_chord, last_sent_chord_next;
  logic [1:0]        click_count, click_count_next;
  logic [TimeW-1:0]  first_click_time, first_click_time_next;
  logic [TimeW-1:0]  second_click_time, second_click_time_next;

  tab_sel_t          sel;
  logic              falls;
  logic [TimeW-1:0]  diff_press;
  logic [TimeW-1:0]  diff_hold;
  logic              in_window;
  logic              past_hold;

  assign sel        = table_of(modifier_bits);
  assign falls      = chord < previous_chord;
  assign diff_press = time_ms - first_click_time;
  assign diff_hold  = time_ms - second_click_time;
  assign in_window  = $signed({diff_press[TimeW-1], diff_press})
                      < $signed({1'b0, {(TimeW-CfgW){1'b0}}, double_click_window});
  assign past_hold  = $signed({diff_hold[TimeW-1], diff_hold})
                      > $signed({1'b0, {(TimeW-CfgW){1'b0}}, hold_delay});

  always_comb begin
    previous_chord_next    = previous_chord;
    sent_mark_next         = sent_mark;
    last_sent_chord_next   = last_sent_chord;
    click_count_next       = click_count;
    first_click_time_next  = first_click_time;
    second_click_time_next = second_click_time;
    result                 = '0;

    if (sel.listed) begin
      if (falls && !sent_mark) begin
        sent_mark_next    = 1'b1;
        result.emit       = 1'b1;
        result.emit_chord = previous_chord;
        if (last_sent_chord != previous_chord) begin
          click_count_next      = 2'd1;
          first_click_time_next = time_ms;
        end
        last_sent_chord_next = previous_chord;
      end

      if (falls) begin
        previous_chord_next = chord;
      end else if (chord != last_sent_chord_next) begin
        sent_mark_next      = 1'b0;
        previous_chord_next = chord;
      end else if (chord > previous_chord) begin
        sent_mark_next         = 1'b0;
        second_click_time_next = time_ms;
        click_count_next       = in_window ? 2'd2 : 2'd1;
        previous_chord_next    = chord;
        if (!in_window) begin
          first_click_time_next = time_ms;
        end
        result.repeating = 1'b1;
      end else if (click_count == 2'd2) begin
        first_click_time_next = time_ms;
        if (past_hold) begin
          result.emit       = 1'b1;
          result.emit_chord = chord;
        end
        result.repeating = 1'b1;
      end

      if (result.emit) begin
        result.emit_table = sel.table_num;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_chord    <= '0;
      sent_mark         <= 1'b0;
      last_sent_chord   <= '0;
      click_count       <= '0;
      first_click_time  <= '0;
      second_click_time <= '0;
    end else if (step) begin
      previous_chord    <= previous_chord_next;
      sent_mark         <= sent_mark_next;
      last_sent_chord   <= last_sent_chord_next;
      click_count       <= click_count_next;
      first_click_time  <= first_click_time_next;
      second_click_time <= second_click_time_next;
    end
  end

endmodule

// File: rtl/chord_release_repeat_detector_core.sv
// Top level: input register, config registers, detector engine and result register.
//
//  channel  | dir | handshake             | payload
//  s_axis   | in  | s_axis_tvalid/tready  | tdata chord, time_ms; tuser modifier_bits
//  m_axis   | out | m_axis_tvalid/tready  | tdata emit, emit_chord, repeating; tuser emit_table
//  cfg      | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One word in, one word out; a word passes through the input register and the result register.
// One word per cycle while the output is ready: input and result register advance together.
// Reset clears valid flags and engine state; window and hold delay return to 300 and 500 ms.
// A stalled output holds both registers; the input still takes a word while its register is empty.
module chord_release_repeat_detector_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] chord, [39:8] time_ms
  input  logic [4:0]  s_axis_tuser,   // [4:0] modifier_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] emit, [8:1] emit_chord, [9] repeating, rest zero
  output logic [2:0]  m_axis_tuser,   // [2:0] emit_table
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import crrd_pkg::*;

  logic              s1_valid;
  logic [ChordW-1:0] s1_chord;
  logic [ModW-1:0]   s1_mods;
  logic [TimeW-1:0]  s1_time;
  logic [CfgW-1:0]   double_click_window;
  logic [CfgW-1:0]   hold_delay;
  logic              adv;
  logic              step;
  result_t           res;
  result_t           out_res;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign step          = s1_valid && adv;
  assign s_axis_tready = !s1_valid || adv;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      double_click_window <= DOUBLE_CLICK_RESET;
      hold_delay          <= HOLD_DELAY_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_DOUBLE_CLICK) begin
        double_click_window <= cfg_data;
      end else if (cfg_index == REG_HOLD_DELAY) begin
        hold_delay <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_chord <= s_axis_tdata[7:0];
      s1_time  <= s_axis_tdata[39:8];
      s1_mods  <= s_axis_tuser;
    end
  end

  crrd_engine u_engine (
    .clk                 (clk),
    .rst                 (rst),
    .step                (step),
    .chord               (s1_chord),
    .modifier_bits       (s1_mods),
    .time_ms             (s1_time),
    .double_click_window (double_click_window),
    .hold_delay          (hold_delay),
    .result              (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {6'd0, out_res.repeating, out_res.emit_chord, out_res.emit};
  assign m_axis_tuser = out_res.emit_table;

  a_step_fills_output: assert property (@(posedge clk) disable iff (rst)
    step |=> m_axis_tvalid)
    else $error("result register not loaded after a step");

  a_quiet_result_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tuser == TAB_NONE
      && m_axis_tdata[8:1] == '0))
    else $error("non-emitting result carries table or chord");

  a_table_in_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser != 3'd7))
    else $error("emit_table out of range");

endmodule

// File: bench/chord_tracker_pkg.sv
// Scoreboard class: tracks chord and click state and checks each result word.
package chord_tracker_pkg;
  import crrd_pkg::*;

  class chord_tracker;
    logic [CfgW-1:0]   window;
    logic [CfgW-1:0]   hold;
    logic [ChordW-1:0] prev;
    logic              sent;
    logic [ChordW-1:0] last_sent;
    logic [1:0]        clicks;
    logic [TimeW-1:0]  first_t;
    logic [TimeW-1:0]  second_t;
    result_t           due_words[$];
    int                mismatches;

    function new();
      window     = DOUBLE_CLICK_RESET;
      hold       = HOLD_DELAY_RESET;
      prev       = '0;
      sent       = 1'b0;
      last_sent  = '0;
      clicks     = '0;
      first_t    = '0;
      second_t   = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] val);
      case (idx)
        REG_DOUBLE_CLICK: window = val;
        REG_HOLD_DELAY:   hold = val;
        default: ;
      endcase
    endfunction

    function bit table_for(input logic [ModW-1:0] mods, output logic [TabW-1:0] tab);
      tab = TAB_NONE;
      case (mods)
        MOD_NONE:       tab = TAB_NONE;
        MOD_SHIFT:      tab = TAB_SHIFT;
        MOD_NUMERIC:    tab = TAB_NUMERIC;
        MOD_FUNCTION:   tab = TAB_FUNCTION;
        MOD_CONTROL:    tab = TAB_CONTROL;
        MOD_ALT:        tab = TAB_ALT;
        MOD_CTRL_SHIFT: tab = TAB_CTRL_SHIFT;
        default:        return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function int elapsed(logic [TimeW-1:0] from_t, logic [TimeW-1:0] to_t);
      return $signed(to_t - from_t);
    endfunction

    function void take_report(logic [ChordW-1:0] chord, logic [ModW-1:0] mods,
                              logic [TimeW-1:0] now);
      result_t         r;
      logic [TabW-1:0] tab;
      r = '0;
      if (!table_for(mods, tab)) begin
        due_words.push_back(r);
        return;
      end
      if (chord < prev && !sent) begin
        sent         = 1'b1;
        r.emit       = 1'b1;
        r.emit_chord = prev;
        if (last_sent != prev) begin
          clicks  = 2'd1;
          first_t = now;
        end
        last_sent = prev;
      end
      if (chord < prev) begin
        prev = chord;
      end else if (chord != last_sent) begin
        sent = 1'b0;
        prev = chord;
      end else if (chord > prev) begin
        sent     = 1'b0;
        second_t = now;
        clicks   = (elapsed(first_t, second_t) < int'({16'h0000, window})) ? 2'd2 : 2'd1;
        prev     = chord;
        if (clicks == 2'd1) first_t = now;
        r.repeating = 1'b1;
      end else if (clicks == 2'd2) begin
        first_t = now;
        if (elapsed(second_t, first_t) > int'({16'h0000, hold})) begin
          r.emit       = 1'b1;
          r.emit_chord = chord;
        end
        r.repeating = 1'b1;
      end
      if (r.emit) r.emit_table = tab;
      due_words.push_back(r);
    endfunction

    function void match_word(result_t got);
      result_t want;
      if (due_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: emit=%0b table=%0d chord=%02h rep=%0b",
                   got.emit, got.emit_table, got.emit_chord, got.repeating);
        return;
      end
      want = due_words.pop_front();
      if (got.emit !== want.emit || got.emit_table !== want.emit_table ||
          got.emit_chord !== want.emit_chord || got.repeating !== want.repeating) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want emit=%0b table=%0d chord=%02h rep=%0b, got %0b %0d %02h %0b",
                   want.emit, want.emit_table, want.emit_chord, want.repeating,
                   got.emit, got.emit_table, got.emit_chord, got.repeating);
      end
    endfunction

    function int pending();
      return due_words.size();
    endfunction
  endclass

endpackage

// File: bench/tb.sv
// Top testbench: drives chord reports and register writes, checks every result word.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crrd_pkg::*;
  import chord_tracker_pkg::*;

  localparam logic [IdxW-1:0] REG_BEYOND = 8'hFF;
  localparam logic [ModW-1:0] LISTED_MODS [7] = '{MOD_NONE, MOD_SHIFT, MOD_NUMERIC,
      MOD_FUNCTION, MOD_CONTROL, MOD_ALT, MOD_CTRL_SHIFT};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [7:0] chord, [39:8] time_ms
  logic [4:0]  s_axis_tuser = '0;   // [4:0] modifier_bits
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [0] emit, [8:1] emit_chord, [9] repeating
  logic [2:0]  m_axis_tuser;        // [2:0] emit_table
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  chord_tracker tracker = new();

  logic [31:0] now_ms = '0;
  int          reports_sent = 0;
  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  int          rx_stall_cycles = 0;

  chord_release_repeat_detector_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        tracker.take_report(s_axis_tdata[7:0], s_axis_tuser, s_axis_tdata[39:8]);
      if (cfg_valid && cfg_ready)
        tracker.write_reg(cfg_index, cfg_data);
      if (m_axis_tvalid && m_axis_tready) begin
        got.emit       = m_axis_tdata[0];
        got.emit_chord = m_axis_tdata[8:1];
        got.repeating  = m_axis_tdata[9];
        got.emit_table = m_axis_tuser;
        tracker.match_word(got);
      end
    end
  end

  initial begin : result_sink
    int gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (rx_stall_cycles > 0) begin
        gap = rx_stall_cycles;
        rx_stall_cycles = 0;
      end else begin
        gap = rx_idle ? $urandom_range(0, 10) : 0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  function automatic int time_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return 0;
    if (r < 55) return $urandom_range(0, 150);
    if (r < 80) return $urandom_range(0, 1200);
    if (r < 90) return $urandom_range(0, 70000);
    if (r < 95) return $urandom();
    return -int'($urandom_range(1, 1000));
  endfunction

  function automatic logic [4:0] maybe_slip(logic [4:0] mods);
    return ($urandom_range(0, 99) < 4) ? 5'($urandom()) : mods;
  endfunction

  task automatic send_after(logic [7:0] chord, logic [4:0] mods, int dt);
    int gap;
    now_ms += 32'(dt);
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now_ms, chord};
    s_axis_tuser  <= mods;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    reports_sent++;
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() > 0);
  endtask

  task automatic lift_keys(logic [7:0] peak, logic [4:0] mods);
    logic [7:0] cur;
    int         downs;
    int         i;
    cur = peak;
    downs = $urandom_range(0, 2);
    for (i = 0; i < downs && cur > 1; i++) begin
      cur = 8'($urandom_range(1, cur - 1));
      send_after(cur, maybe_slip(mods), time_step());
    end
    if ($urandom_range(0, 9) != 0) send_after(8'h00, maybe_slip(mods), time_step());
  endtask

  task automatic play_gesture();
    logic [7:0] peak;
    logic [7:0] lo;
    logic [4:0] mods;
    int         kind;
    int         ups;
    int         i;
    mods = ($urandom_range(0, 99) < 85) ? LISTED_MODS[$urandom_range(0, 6)] : 5'($urandom());
    peak = 8'($urandom_range(1, 255));
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 4)) send_after(8'($urandom()), 5'($urandom()), time_step());
      return;
    end
    lo = '0;
    ups = $urandom_range(0, 2);
    for (i = 0; i < ups; i++) begin
      lo = 8'($urandom_range(lo, peak));
      send_after(lo, maybe_slip(mods), time_step());
    end
    send_after(peak, maybe_slip(mods), time_step());
    lift_keys(peak, mods);
    if (kind >= 50) begin
      send_after(peak, maybe_slip(mods), time_step());
      repeat ($urandom_range(0, 8)) send_after(peak, maybe_slip(mods), time_step());
      lift_keys(peak, mods);
    end
  endtask

  initial begin : stimulus
    int p;
    int i;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // start just below the time wrap
    now_ms = 32'hFFFF_FF80;
    send_after(8'h00, MOD_NONE, 0);
    send_after(8'hFF, MOD_CTRL_SHIFT, 5);
    send_after(8'h00, MOD_CTRL_SHIFT, 5);
    send_after(8'h7F, 5'h1F, 5);
    send_after(8'hAA, MOD_SHIFT | MOD_NUMERIC, 5);
    for (i = 0; i < 6; i++) begin
      send_after(8'(8'h11 * (i + 1)), LISTED_MODS[i], 7);
      send_after(8'h00, LISTED_MODS[i], 7);
    end
    // double click, auto-repeat, time going backwards
    send_after(8'h42, MOD_NONE, 5);
    send_after(8'h00, MOD_NONE, 50);
    send_after(8'h42, MOD_NONE, 100);
    send_after(8'h42, MOD_NONE, 100);
    send_after(8'h42, MOD_NONE, 500);
    send_after(8'h42, MOD_NONE, -700);
    send_after(8'h00, MOD_NONE, 10);
    send_after(8'h42, MOD_NONE, -5000);

    for (p = 1; p <= 5; p++) begin
      drain();
      case (p)
        1: begin
          write_reg(REG_DOUBLE_CLICK, 16'h0000);
          write_reg(REG_HOLD_DELAY, 16'h0000);
          write_reg(REG_BEYOND, 16'hFFFF);
        end
        2: begin
          write_reg(REG_DOUBLE_CLICK, 16'hFFFF);
          write_reg(REG_HOLD_DELAY, 16'hFFFF);
        end
        3: begin
          write_reg(REG_DOUBLE_CLICK, 16'($urandom_range(0, 1500)));
          write_reg(REG_HOLD_DELAY, 16'($urandom_range(0, 1500)));
        end
        4: begin
          write_reg(REG_DOUBLE_CLICK, 16'($urandom_range(100, 600)));
          write_reg(REG_HOLD_DELAY, 16'($urandom_range(0, 800)));
        end
        default: begin
          write_reg(REG_DOUBLE_CLICK, DOUBLE_CLICK_RESET);
          write_reg(REG_HOLD_DELAY, HOLD_DELAY_RESET);
        end
      endcase
      cfg_valid <= 1'b0;
      tx_idle = (p == 1 || p == 2) ? 1'b0 : 1'($urandom_range(0, 1));
      rx_idle = (p == 1) ? 1'b0 : 1'($urandom_range(0, 1));
      if (p == 2) rx_stall_cycles = 300;
      while (reports_sent < 25 + p * 365) begin
        if (p > 1 && $urandom_range(0, 99) < 8) begin
          tx_idle = 1'($urandom_range(0, 1));
          rx_idle = 1'($urandom_range(0, 1));
        end
        play_gesture();
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

// File: chord_release_repeat_detector_core.f
rtl/crrd_pkg.sv
rtl/crrd_engine.sv
rtl/chord_release_repeat_detector_core.sv
bench/chord_tracker_pkg.sv
bench/tb.sv
